// ===== src/rgbge_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbge_pkg: shared types and constants
// Field widths, register and opcode codes, item and configuration structs.
// ----------------------------------------------------------------------------
package rgbge_pkg;

	localparam int DIM_W      = 11;
	localparam int FRAC_W     = 16;
	localparam int SCALE_W    = DIM_W + FRAC_W;
	localparam int PIX_W      = 16;
	localparam int PX_W       = 10;
	localparam int PY_W       = 9;
	localparam int EIDX_W     = 17;
	localparam int EVAL_W     = 8;
	localparam int LIN_W      = 2 * DIM_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int QDEPTH     = 4;

	localparam int DEF_FRAME_WIDTH    = 640;
	localparam int DEF_FRAME_HEIGHT   = 512;
	localparam int DEF_EDGE_MAP_DEPTH = 131072;
	localparam int DEF_EDGE_MAX_DIM   = 1024;

	localparam logic [EVAL_W-1:0] EDGE_MARK   = 8'd255;
	localparam logic [PIX_W-1:0]  COLOR_RESET = 16'h07E0;

	// rounding offsets and reciprocals for x/31 and x/63 (exact over the field range)
	localparam int HALF5       = 15;
	localparam int HALF6       = 31;
	localparam int RECIP31     = 33826;
	localparam int RECIP63     = 16645;
	localparam int RECIP_SHIFT = 20;

	localparam int LUMA_R = 77;
	localparam int LUMA_G = 150;
	localparam int LUMA_B = 29;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EDGE_WIDTH  = 2'd0,
		REG_EDGE_HEIGHT = 2'd1,
		REG_EDGE_COLOR  = 2'd2,
		REG_OVERLAY_EN  = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_LOAD  = 1'b1
	} op_t;

	typedef struct packed {
		logic              is_load;
		logic              load_ok;
		logic              mark;
		logic [PIX_W-1:0]  pixel;
		logic [PX_W-1:0]   px;
		logic [PY_W-1:0]   py;
		logic [EIDX_W-1:0] eidx;
	} item_t;

	typedef struct packed {
		logic [DIM_W-1:0]   ew;
		logic [DIM_W-1:0]   eh;
		logic [PIX_W-1:0]   color;
		logic               en;
		logic [SCALE_W-1:0] xs;
		logic [SCALE_W-1:0] ys;
	} cfg_t;

endpackage
`default_nettype wire

// ===== src/rgbge_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbge_cfg: configuration registers and map scales
// Holds the registers and derives the x and y map scales at the dimension
// write by multiplying with a constant reciprocal of the frame size.
// ----------------------------------------------------------------------------
module rgbge_cfg #(
	parameter int FRAME_WIDTH  = rgbge_pkg::DEF_FRAME_WIDTH,
	parameter int FRAME_HEIGHT = rgbge_pkg::DEF_FRAME_HEIGHT,
	parameter int EDGE_MAX_DIM = rgbge_pkg::DEF_EDGE_MAX_DIM
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [rgbge_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [rgbge_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output rgbge_pkg::cfg_t                          cfg
);
	import rgbge_pkg::*;

	localparam int SAT_W  = 13;
	// extra shift keeps dim * reciprocal exact for frame sizes up to 4096
	localparam int RSH    = DIM_W + 12;
	localparam int RC_W   = FRAC_W + RSH + 1;
	localparam int PROD_W = RSH + SCALE_W;

	localparam longint unsigned XRECIP_L =
		((64'd1 << (FRAC_W + RSH)) + 64'(FRAME_WIDTH) - 64'd1) / 64'(FRAME_WIDTH);
	localparam longint unsigned YRECIP_L =
		((64'd1 << (FRAC_W + RSH)) + 64'(FRAME_HEIGHT) - 64'd1) / 64'(FRAME_HEIGHT);
	localparam logic [RC_W-1:0] XRECIP = RC_W'(XRECIP_L);
	localparam logic [RC_W-1:0] YRECIP = RC_W'(YRECIP_L);

	logic [DIM_W-1:0]   ew_q, eh_q, dim_sat;
	logic [PIX_W-1:0]   color_q;
	logic               en_q;
	logic [SCALE_W-1:0] xs_q, ys_q;
	logic [PROD_W-1:0]  xprod, yprod;

	always_comb begin
		dim_sat = cfg_wdata[DIM_W-1:0];
		if (SAT_W'(cfg_wdata[DIM_W-1:0]) > SAT_W'(EDGE_MAX_DIM)) begin
			dim_sat = DIM_W'(EDGE_MAX_DIM);
		end
	end

	assign xprod = PROD_W'(dim_sat) * PROD_W'(XRECIP);
	assign yprod = PROD_W'(dim_sat) * PROD_W'(YRECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ew_q    <= '0;
			eh_q    <= '0;
			color_q <= COLOR_RESET;
			en_q    <= 1'b0;
			xs_q    <= '0;
			ys_q    <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_EDGE_WIDTH: begin
					ew_q <= dim_sat;
					xs_q <= xprod[RSH +: SCALE_W];
				end
				REG_EDGE_HEIGHT: begin
					eh_q <= dim_sat;
					ys_q <= yprod[RSH +: SCALE_W];
				end
				REG_EDGE_COLOR:  color_q <= cfg_wdata[PIX_W-1:0];
				REG_OVERLAY_EN:  en_q    <= cfg_wdata[0];
			endcase
		end
	end

	assign cfg.ew    = ew_q;
	assign cfg.eh    = eh_q;
	assign cfg.color = color_q;
	assign cfg.en    = en_q;
	assign cfg.xs    = xs_q;
	assign cfg.ys    = ys_q;

endmodule
`default_nettype wire

// ===== src/rgbge_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbge_front: input acceptance and classification
// Takes items while the queue has room, and tags each as pixel or mask
// load with its load checks resolved.
// ----------------------------------------------------------------------------
module rgbge_front #(
	parameter int EDGE_MAP_DEPTH = rgbge_pkg::DEF_EDGE_MAP_DEPTH
) (
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             opcode,
	input  wire logic [rgbge_pkg::PIX_W-1:0]      pixel_value,
	input  wire logic [rgbge_pkg::PX_W-1:0]       pixel_x,
	input  wire logic [rgbge_pkg::PY_W-1:0]       pixel_y,
	input  wire logic [rgbge_pkg::EIDX_W-1:0]     edge_index,
	input  wire logic [rgbge_pkg::EVAL_W-1:0]     edge_value,
	input  wire logic                             q_full,
	output logic                                  push,
	output rgbge_pkg::item_t                      item
);
	import rgbge_pkg::*;

	assign in_stall = q_full;
	assign push     = in_valid && !in_stall;

	assign item.is_load = (op_t'(opcode) == OP_LOAD);
	assign item.load_ok = (LIN_W'(edge_index) < LIN_W'(EDGE_MAP_DEPTH));
	assign item.mark    = (edge_value == EDGE_MARK);
	assign item.pixel   = pixel_value;
	assign item.px      = pixel_x;
	assign item.py      = pixel_y;
	assign item.eidx    = edge_index;

endmodule
`default_nettype wire

// ===== src/rgbge_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbge_fifo: item queue between front and back
// Small register queue; decouples input stalls from output stalls.
// ----------------------------------------------------------------------------
module rgbge_fifo (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  rgbge_pkg::item_t wr_item,
	input  wire logic        pop,
	output logic             full,
	output logic             not_empty,
	output rgbge_pkg::item_t head
);
	import rgbge_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	item_t         mem_q [QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/rgbge_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbge_back: grey conversion, map lookup and result output
// Five-stage pipeline: expand and scale, luma and clamp, linear address,
// mask access, output register. Loads write the mask in the access stage.
// ----------------------------------------------------------------------------
module rgbge_back #(
	parameter int EDGE_MAP_DEPTH = rgbge_pkg::DEF_EDGE_MAP_DEPTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  rgbge_pkg::item_t                  head,
	input  wire logic                         head_valid,
	output logic                              pop,
	input  rgbge_pkg::cfg_t                   cfg,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [rgbge_pkg::PIX_W-1:0]       out_pixel,
	output logic                              edge_hit
);
	import rgbge_pkg::*;

	localparam int AW   = (EDGE_MAP_DEPTH > 1) ? $clog2(EDGE_MAP_DEPTH) : 1;
	localparam int MX_W = PX_W + SCALE_W;
	localparam int MY_W = PY_W + SCALE_W;
	localparam int EX_W = MX_W - FRAC_W;
	localparam int EY_W = MY_W - FRAC_W;
	localparam int XR_W = 13;
	localparam int XG_W = 14;
	localparam int RP_W = 29;

	logic mask_mem [EDGE_MAP_DEPTH];

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic load_s1, load_s2, load_s3, load_s4;
	logic ok_s1, ok_s2, ok_s3;
	logic mark_s1, mark_s2, mark_s3;
	logic [EIDX_W-1:0] eidx_s1, eidx_s2, eidx_s3;

	logic [4:0]       r5, b5;
	logic [5:0]       g6;
	logic [XR_W-1:0]  xr, xb;
	logic [XG_W-1:0]  xg;
	logic [7:0]       r8_s1, g8_s1, b8_s1;
	logic [MX_W-1:0]  mx_s1;
	logic [MY_W-1:0]  my_s1;

	logic [EX_W-1:0]  ex_raw;
	logic [EY_W-1:0]  ey_raw;
	logic [DIM_W-1:0] ex_c, ey_c, ex_s2, ey_s2;
	logic [15:0]      pr, pg, pb;
	logic [7:0]       y_c, y_s2;

	logic [LIN_W-1:0] lin_c, lin_s3;
	logic [PIX_W-1:0] grey_s3, grey_s4, pix_q;
	logic             inmap_s4, bit_s4, hit_q, hit_c;
	logic [AW-1:0]    wa, ra;

	// the whole pipeline moves while the output register can take an item
	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && head_valid;

	// stage 1: field expansion with rounding, coordinate scaling
	assign r5 = head.pixel[15:11];
	assign g6 = head.pixel[10:5];
	assign b5 = head.pixel[4:0];
	assign xr = XR_W'({r5, 8'h00}) - XR_W'(r5) + XR_W'(HALF5);
	assign xg = XG_W'({g6, 8'h00}) - XG_W'(g6) + XG_W'(HALF6);
	assign xb = XR_W'({b5, 8'h00}) - XR_W'(b5) + XR_W'(HALF5);

	always_ff @(posedge clk) begin
		if (adv) begin
			load_s1 <= head.is_load;
			ok_s1   <= head.load_ok;
			mark_s1 <= head.mark;
			eidx_s1 <= head.eidx;
			r8_s1   <= 8'((RP_W'(xr) * RP_W'(RECIP31)) >> RECIP_SHIFT);
			g8_s1   <= 8'((RP_W'(xg) * RP_W'(RECIP63)) >> RECIP_SHIFT);
			b8_s1   <= 8'((RP_W'(xb) * RP_W'(RECIP31)) >> RECIP_SHIFT);
			mx_s1   <= MX_W'(head.px) * MX_W'(cfg.xs);
			my_s1   <= MY_W'(head.py) * MY_W'(cfg.ys);
		end
	end

	// stage 2: luma sum, clamp onto the map
	assign ex_raw = mx_s1[MX_W-1:FRAC_W];
	assign ey_raw = my_s1[MY_W-1:FRAC_W];
	assign ex_c   = (ex_raw >= EX_W'(cfg.ew)) ? cfg.ew - 1'b1 : ex_raw[DIM_W-1:0];
	assign ey_c   = (ey_raw >= EY_W'(cfg.eh)) ? cfg.eh - 1'b1 : ey_raw[DIM_W-1:0];
	assign pr     = 16'(r8_s1) * 16'(LUMA_R);
	assign pg     = 16'(g8_s1) * 16'(LUMA_G);
	assign pb     = 16'(b8_s1) * 16'(LUMA_B);
	assign y_c    = 8'((pr >> 8) + (pg >> 8) + (pb >> 8));

	always_ff @(posedge clk) begin
		if (adv) begin
			load_s2 <= load_s1;
			ok_s2   <= ok_s1;
			mark_s2 <= mark_s1;
			eidx_s2 <= eidx_s1;
			ex_s2   <= ex_c;
			ey_s2   <= ey_c;
			y_s2    <= y_c;
		end
	end

	// stage 3: linear mask address, grey repack
	assign lin_c = LIN_W'(ey_s2) * LIN_W'(cfg.ew) + LIN_W'(ex_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			load_s3 <= load_s2;
			ok_s3   <= ok_s2;
			mark_s3 <= mark_s2;
			eidx_s3 <= eidx_s2;
			lin_s3  <= lin_c;
			grey_s3 <= {y_s2[7:3], y_s2[7:2], y_s2[7:3]};
		end
	end

	// stage 4: one mask access per cycle while the pipeline advances, write for loads, read for pixels
	assign wa = AW'(eidx_s3);
	assign ra = lin_s3[AW-1:0];

	always_ff @(posedge clk) begin
		if (adv && v_s3) begin
			if (load_s3) begin
				if (ok_s3) begin
					mask_mem[wa] <= mark_s3;
				end
			end else begin
				bit_s4 <= mask_mem[ra];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			load_s4  <= load_s3;
			grey_s4  <= grey_s3;
			inmap_s4 <= (lin_s3 < LIN_W'(EDGE_MAP_DEPTH));
		end
	end

	// stage 5: overlay decision into the output register
	assign hit_c = cfg.en && (cfg.ew != '0) && (cfg.eh != '0) && inmap_s4 && bit_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_q <= hit_c ? cfg.color : grey_s4;
			hit_q <= hit_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= head_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			// drop load items here: they give no result
			out_valid_q <= v_s4 && !load_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = pix_q;
	assign edge_hit  = hit_q;

endmodule
`default_nettype wire

// ===== src/rgb565_gray_edge_overlay.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted item passes through the queue, the back stages and the output register.
// Throughput: one item per cycle while the output is not stalled, set by the single-port mask access stage.
// An output stall holds the back pipeline; the 4-entry queue then fills and
// stalls the input. Map scales are registered with the dimension write.
// Reset clears registers, queue and pipeline control; the edge mask is not
// cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
// rgb565_gray_edge_overlay: RGB565 greyscale with edge mask overlay
// Front accepts and classifies items, a queue decouples it from the back
// pipeline that converts pixels and applies the edge mask.
// ----------------------------------------------------------------------------
module rgb565_gray_edge_overlay #(
	parameter int FRAME_WIDTH    = rgbge_pkg::DEF_FRAME_WIDTH,
	parameter int FRAME_HEIGHT   = rgbge_pkg::DEF_FRAME_HEIGHT,
	parameter int EDGE_MAP_DEPTH = rgbge_pkg::DEF_EDGE_MAP_DEPTH,
	parameter int EDGE_MAX_DIM   = rgbge_pkg::DEF_EDGE_MAX_DIM
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [rgbge_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rgbge_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              opcode,
	input  wire logic [rgbge_pkg::PIX_W-1:0]       pixel_value,
	input  wire logic [rgbge_pkg::PX_W-1:0]        pixel_x,
	input  wire logic [rgbge_pkg::PY_W-1:0]        pixel_y,
	input  wire logic [rgbge_pkg::EIDX_W-1:0]      edge_index,
	input  wire logic [rgbge_pkg::EVAL_W-1:0]      edge_value,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [rgbge_pkg::PIX_W-1:0]            out_pixel,
	output logic                                   edge_hit
);
	import rgbge_pkg::*;

	cfg_t  cfg;
	item_t wr_item, head;
	logic  push, pop, q_full, q_not_empty;

	rgbge_cfg #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT),
		.EDGE_MAX_DIM (EDGE_MAX_DIM)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	rgbge_front #(
		.EDGE_MAP_DEPTH (EDGE_MAP_DEPTH)
	) u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.pixel_value (pixel_value),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.edge_index  (edge_index),
		.edge_value  (edge_value),
		.q_full      (q_full),
		.push        (push),
		.item        (wr_item)
	);

	rgbge_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_item   (wr_item),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	rgbge_back #(
		.EDGE_MAP_DEPTH (EDGE_MAP_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (q_not_empty),
		.pop        (pop),
		.cfg        (cfg),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_pixel  (out_pixel),
		.edge_hit   (edge_hit)
	);

endmodule
`default_nettype wire
